[hdl/mcc_pkg.sv]
package mcc_pkg;

  // Default sizes for the top level
  localparam int NUM_COINS_DEF  = 8;
  localparam int MAX_TARGET_DEF = 1023;

  // Fixed field widths
  localparam int VAL_W    = 10;
  localparam int LEN_W    = 10;
  localparam int OP_W     = 2;
  localparam int IN_DW    = 16;
  localparam int OUT_DW   = 24;
  localparam logic [VAL_W-1:0] CNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SOLVE  = 2'd2
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_AMT_RD,
    S_AMT_CHK,
    S_SLOT,
    S_RELAX,
    S_WB_RD,
    S_WB_CHK,
    S_EMIT
  } state_t;

  // Requests from the sequencer to the coin bank
  typedef struct packed {
    logic clear_set;
    logic append;
    logic clr_counts;
    logic inc_count;
  } coin_ctl_t;

endpackage

[hdl/mcc_table_ram.sv]
module mcc_table_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/mcc_coin_bank.sv]
module mcc_coin_bank #(
  parameter int NUM_COINS = mcc_pkg::NUM_COINS_DEF,
  parameter int SW        = 3,
  parameter int CW        = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mcc_pkg::coin_ctl_t       ctl,
  input  logic [mcc_pkg::VAL_W-1:0] append_val,
  input  logic [SW-1:0]            idx,
  output logic [mcc_pkg::VAL_W-1:0] coin_val,
  output logic [mcc_pkg::VAL_W-1:0] count_val,
  output logic [CW-1:0]            loaded
);

  logic [mcc_pkg::VAL_W-1:0] coin_r  [NUM_COINS];
  logic [mcc_pkg::VAL_W-1:0] count_r [NUM_COINS];
  logic [CW-1:0]             loaded_r;
  logic                      full;

  assign full = (32'(loaded_r) >= 32'(NUM_COINS));

  // Track how many slots hold a coin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
    end else if (ctl.clear_set) begin
      loaded_r <= '0;
    end else if (ctl.append && !full) begin
      loaded_r <= CW'(loaded_r + 1'b1);
    end
  end

  // Store appended coin values
  always_ff @(posedge clk) begin
    if (ctl.append && !full) begin
      coin_r[loaded_r[SW-1:0]] <= append_val;
    end
  end

  // Per-slot usage counts, saturating
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_counts) begin
      for (int i = 0; i < NUM_COINS; i++) begin
        count_r[i] <= '0;
      end
    end else if (ctl.inc_count && count_r[idx] != mcc_pkg::CNT_MAX) begin
      count_r[idx] <= mcc_pkg::VAL_W'(count_r[idx] + 1'b1);
    end
  end

  assign coin_val  = coin_r[idx];
  assign count_val = count_r[idx];
  assign loaded    = loaded_r;

`ifndef SYNTHESIS
  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(loaded_r) <= 32'(NUM_COINS))
    else $error("coin bank holds more coins than slots");

  a_inc_not_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.inc_count && ctl.clr_counts))
    else $error("count increment collides with count clear");
`endif

endmodule

[hdl/min_coin_change_solver.sv]
// Channel  Direction  Ports                       Payload
// in_      slave      in_tvalid/in_tready         tdata: operand_value; tuser: opcode
// out_     master     out_tvalid/out_tready       tdata: coin_value, coin_count;
//                                                 tuser: found; tlast: is_last
// Clear and append act in the idle state. A solve for target T with N loaded
// coins clears table entries 0..T, reads each amount, and for each reached
// amount skips unusable coins and relaxes the rest; then it walks back from T,
// counting the coin of each step, and emits one result per loaded coin, one
// per cycle while the output is free.
// Reset is synchronous (rst_n low); the table needs no clearing after reset.
// Input is taken only in the idle state; a held result does not block it.
module min_coin_change_solver #(
  parameter int NUM_COINS  = mcc_pkg::NUM_COINS_DEF,
  parameter int MAX_TARGET = mcc_pkg::MAX_TARGET_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [mcc_pkg::IN_DW-1:0]  in_tdata,   // operand_value[9:0]
  input  logic [mcc_pkg::OP_W-1:0]   in_tuser,   // opcode[1:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [mcc_pkg::OUT_DW-1:0] out_tdata,  // coin_value[9:0], coin_count[19:10]
  output logic                       out_tuser,  // found[0]
  output logic                       out_tlast
);

  localparam int VAL_W = mcc_pkg::VAL_W;
  localparam int LEN_W = mcc_pkg::LEN_W;
  localparam int DEPTH = MAX_TARGET + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
  localparam int CW    = $clog2(NUM_COINS + 1);
  localparam int TW    = ((AW > VAL_W) ? AW : VAL_W) + 1;
  localparam int DW    = 1 + LEN_W + SW;

  mcc_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]    amt_r, amt_nxt;
  logic [AW-1:0]    dst_r, dst_nxt;
  logic [VAL_W-1:0] target_r, target_nxt;
  logic [LEN_W-1:0] amt_len_r, amt_len_nxt;
  logic [CW-1:0]    slot_r, slot_nxt;
  logic [CW-1:0]    emit_r, emit_nxt;
  logic             first_r, first_nxt;
  logic             found_r, found_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]      out_val_r, out_val_nxt;
  logic [VAL_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic                  out_found_r, out_found_nxt;
  logic                  out_last_r, out_last_nxt;

  // Table memory and coin bank hookup
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic          rd_reached;
  logic [LEN_W-1:0] rd_len;
  logic [SW-1:0] rd_slot;

  mcc_pkg::coin_ctl_t coin_ctl;
  logic [SW-1:0]      coin_idx;
  logic [VAL_W-1:0]   coin_val, count_val;
  logic [CW-1:0]      loaded;

  logic [mcc_pkg::OP_W-1:0] in_op;
  logic [VAL_W-1:0]         in_operand;
  logic [TW-1:0]            dst_sum;
  logic                     amt_at_tgt;
  logic                     out_free;
  logic                     emit_last;
  logic [LEN_W-1:0]         new_len;

  assign in_op      = in_tuser;
  assign in_operand = in_tdata[VAL_W-1:0];

  assign rd_reached = ram_rdata[DW-1];
  assign rd_len     = ram_rdata[SW +: LEN_W];
  assign rd_slot    = ram_rdata[SW-1:0];

  assign dst_sum    = TW'(amt_r) + TW'(coin_val);
  assign amt_at_tgt = (TW'(amt_r) == TW'(target_r));
  assign out_free   = !out_valid_r || out_tready;
  assign emit_last  = (loaded == '0) || (CW'(emit_r + 1'b1) == loaded);
  assign new_len    = LEN_W'(amt_len_r + 1'b1);

  mcc_table_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mcc_coin_bank #(
    .NUM_COINS (NUM_COINS),
    .SW        (SW),
    .CW        (CW)
  ) u_coins (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (coin_ctl),
    .append_val (in_operand),
    .idx        (coin_idx),
    .coin_val   (coin_val),
    .count_val  (count_val),
    .loaded     (loaded)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    amt_r       <= amt_nxt;
    dst_r       <= dst_nxt;
    target_r    <= target_nxt;
    amt_len_r   <= amt_len_nxt;
    slot_r      <= slot_nxt;
    emit_r      <= emit_nxt;
    first_r     <= first_nxt;
    found_r     <= found_nxt;
    out_val_r   <= out_val_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Sequencer: table clear, relaxation, walk back, result emission
  always_comb begin
    state_nxt     = state_r;
    amt_nxt       = amt_r;
    dst_nxt       = dst_r;
    target_nxt    = target_r;
    amt_len_nxt   = amt_len_r;
    slot_nxt      = slot_r;
    emit_nxt      = emit_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = amt_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = amt_r;
    coin_ctl      = '0;
    coin_idx      = slot_r[SW-1:0];

    unique case (state_r)
      mcc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_op)
            mcc_pkg::OP_CLEAR:  coin_ctl.clear_set = 1'b1;
            mcc_pkg::OP_APPEND: coin_ctl.append = 1'b1;
            mcc_pkg::OP_SOLVE: begin
              coin_ctl.clr_counts = 1'b1;
              target_nxt = in_operand;
              emit_nxt   = '0;
              amt_nxt    = '0;
              if (32'(in_operand) > 32'(MAX_TARGET)) begin
                found_nxt = 1'b0;
                state_nxt = mcc_pkg::S_EMIT;
              end else begin
                state_nxt = mcc_pkg::S_CLEAR;
              end
            end
            default: ;
          endcase
        end
      end

      // Mark amounts 0..target unreached, amount 0 reached with length 0
      mcc_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = amt_r;
        ram_wdata = (amt_r == '0) ? {1'b1, {(DW-1){1'b0}}} : '0;
        if (amt_at_tgt) begin
          amt_nxt   = '0;
          state_nxt = mcc_pkg::S_AMT_RD;
        end else begin
          amt_nxt = AW'(amt_r + 1'b1);
        end
      end

      mcc_pkg::S_AMT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = amt_r;
        state_nxt = mcc_pkg::S_AMT_CHK;
      end

      // Skip unreached amounts, else start the coin scan
      mcc_pkg::S_AMT_CHK: begin
        if (rd_reached) begin
          amt_len_nxt = rd_len;
          slot_nxt    = '0;
          state_nxt   = mcc_pkg::S_SLOT;
        end else if (amt_at_tgt) begin
          amt_nxt   = AW'(target_r);
          first_nxt = 1'b1;
          state_nxt = mcc_pkg::S_WB_RD;
        end else begin
          amt_nxt   = AW'(amt_r + 1'b1);
          state_nxt = mcc_pkg::S_AMT_RD;
        end
      end

      // Pick the next usable coin and fetch its destination entry
      mcc_pkg::S_SLOT: begin
        coin_idx = slot_r[SW-1:0];
        if (slot_r == loaded) begin
          if (amt_at_tgt) begin
            amt_nxt   = AW'(target_r);
            first_nxt = 1'b1;
            state_nxt = mcc_pkg::S_WB_RD;
          end else begin
            amt_nxt   = AW'(amt_r + 1'b1);
            state_nxt = mcc_pkg::S_AMT_RD;
          end
        end else if (coin_val == '0 || dst_sum > TW'(target_r)) begin
          slot_nxt = CW'(slot_r + 1'b1);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = dst_sum[AW-1:0];
          dst_nxt   = dst_sum[AW-1:0];
          state_nxt = mcc_pkg::S_RELAX;
        end
      end

      // Replace only unreached or strictly longer entries
      mcc_pkg::S_RELAX: begin
        if (!rd_reached || rd_len > new_len) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = {1'b1, new_len, slot_r[SW-1:0]};
        end
        slot_nxt  = CW'(slot_r + 1'b1);
        state_nxt = mcc_pkg::S_SLOT;
      end

      mcc_pkg::S_WB_RD: begin
        ram_re    = 1'b1;
        ram_raddr = amt_r;
        state_nxt = mcc_pkg::S_WB_CHK;
      end

      // Count the winning coin and step back by its value
      mcc_pkg::S_WB_CHK: begin
        coin_idx  = rd_slot;
        first_nxt = 1'b0;
        if (first_r) begin
          found_nxt = rd_reached;
        end
        if ((first_r && !rd_reached) || amt_r == '0 || coin_val == '0 ||
            TW'(coin_val) > TW'(amt_r)) begin
          state_nxt = mcc_pkg::S_EMIT;
        end else begin
          coin_ctl.inc_count = 1'b1;
          amt_nxt   = AW'(TW'(amt_r) - TW'(coin_val));
          state_nxt = mcc_pkg::S_WB_RD;
        end
      end

      // One result per loaded slot, or a single empty result
      mcc_pkg::S_EMIT: begin
        coin_idx = emit_r[SW-1:0];
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_val_nxt   = (loaded == '0) ? '0 : coin_val;
          out_cnt_nxt   = (loaded != '0 && found_r) ? count_val : '0;
          out_last_nxt  = emit_last;
          if (emit_last) begin
            state_nxt = mcc_pkg::S_IDLE;
          end else begin
            emit_nxt = CW'(emit_r + 1'b1);
          end
        end
      end

      default: state_nxt = mcc_pkg::S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mcc_pkg::OUT_DW - 2*VAL_W){1'b0}}, out_cnt_r, out_val_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("table read and write hit the same entry");

  a_dst_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcc_pkg::S_RELAX) |-> (TW'(dst_r) <= TW'(target_r)))
    else $error("relaxation beyond the target amount");

  a_walk_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcc_pkg::S_WB_CHK && !first_r) |-> rd_reached)
    else $error("walk back reached an unreached amount");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_tdata)))
    else $error("pending result overwritten");
`endif

endmodule
